// ----- rtl/tbc_pkg.sv -----
// Shared types and constants of the triangle barycentric weight unit.
package tbc_pkg;

    localparam int COORD_W   = 32;
    localparam int VEC_W     = COORD_W + 1;
    localparam int PP_W      = 2 * VEC_W;
    localparam int DOT_W     = PP_W + 1;
    localparam int DMAG_W    = DOT_W - 1;
    localparam int LIMB_W    = DMAG_W / 2;
    localparam int PROD_W    = 2 * DMAG_W + 1;
    localparam int DIFF_W    = PROD_W + 1;
    localparam int MAG_W     = DIFF_W - 1;
    localparam int QUO_W     = 32;
    localparam int WGT_W     = 32;
    localparam int EPS_SHIFT = 40;
    localparam int DET_EPS   = 1099512;
    localparam int LEN_EPS   = 10995;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [WGT_W-1:0]   t_weight;

    typedef enum logic [1:0] {
        CASE_TRI  = 2'd0,
        CASE_AB   = 2'd1,
        CASE_AC   = 2'd2,
        CASE_ZERO = 2'd3
    } t_case;

    typedef struct packed {
        t_coord a_x;
        t_coord a_y;
        t_coord a_z;
        t_coord b_x;
        t_coord b_y;
        t_coord b_z;
        t_coord c_x;
        t_coord c_y;
        t_coord c_z;
        t_coord p_x;
        t_coord p_y;
        t_coord p_z;
    } t_in_item;

    typedef struct packed {
        t_weight weight_a;
        t_weight weight_b;
        t_weight weight_c;
        t_case   case_code;
        logic    saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [DOT_W-1:0] d00;
        logic signed [DOT_W-1:0] d01;
        logic signed [DOT_W-1:0] d11;
        logic signed [DOT_W-1:0] d20;
        logic signed [DOT_W-1:0] d21;
    } t_dots;

    typedef struct packed {
        logic  valid;
        logic  to_b;
        t_case code;
    } t_tag;

    function automatic logic signed [VEC_W-1:0] sdiff(t_coord x, t_coord y);
        sdiff = $signed({x[COORD_W-1], x}) - $signed({y[COORD_W-1], y});
    endfunction

endpackage

// ----- rtl/tbc_dot.sv -----
// Edge vectors and their five dot products, three register stages.
module tbc_dot (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  tbc_pkg::t_in_item i_item,
    output logic              o_valid,
    output tbc_pkg::t_dots    o_dots
);
    import tbc_pkg::*;

    logic signed [VEC_W-1:0] n_v [9];
    logic signed [VEC_W-1:0] r_v [9];
    logic signed [PP_W-1:0]  r_pr [5][3];
    t_dots                   n_dots;
    t_dots                   r_dots;
    logic                    r_val1, r_val2, r_val3;

    always_comb begin
        n_v[0] = sdiff(i_item.b_x, i_item.a_x);
        n_v[1] = sdiff(i_item.b_y, i_item.a_y);
        n_v[2] = sdiff(i_item.b_z, i_item.a_z);
        n_v[3] = sdiff(i_item.c_x, i_item.a_x);
        n_v[4] = sdiff(i_item.c_y, i_item.a_y);
        n_v[5] = sdiff(i_item.c_z, i_item.a_z);
        n_v[6] = sdiff(i_item.p_x, i_item.a_x);
        n_v[7] = sdiff(i_item.p_y, i_item.a_y);
        n_v[8] = sdiff(i_item.p_z, i_item.a_z);
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
    end

    for (genvar k = 0; k < 3; k++) begin : g_prod
        always_ff @(posedge i_clk) begin
            r_pr[0][k] <= r_v[k] * r_v[k];
            r_pr[1][k] <= r_v[k] * r_v[3+k];
            r_pr[2][k] <= r_v[3+k] * r_v[3+k];
            r_pr[3][k] <= r_v[6+k] * r_v[k];
            r_pr[4][k] <= r_v[6+k] * r_v[3+k];
        end
    end

    always_comb begin
        n_dots.d00 = DOT_W'(r_pr[0][0]) + DOT_W'(r_pr[0][1]) + DOT_W'(r_pr[0][2]);
        n_dots.d01 = DOT_W'(r_pr[1][0]) + DOT_W'(r_pr[1][1]) + DOT_W'(r_pr[1][2]);
        n_dots.d11 = DOT_W'(r_pr[2][0]) + DOT_W'(r_pr[2][1]) + DOT_W'(r_pr[2][2]);
        n_dots.d20 = DOT_W'(r_pr[3][0]) + DOT_W'(r_pr[3][1]) + DOT_W'(r_pr[3][2]);
        n_dots.d21 = DOT_W'(r_pr[4][0]) + DOT_W'(r_pr[4][1]) + DOT_W'(r_pr[4][2]);
    end

    always_ff @(posedge i_clk) begin
        r_dots <= n_dots;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val1 <= 1'b0;
            r_val2 <= 1'b0;
            r_val3 <= 1'b0;
        end else begin
            r_val1 <= i_valid;
            r_val2 <= r_val1;
            r_val3 <= r_val2;
        end
    end

    assign o_valid = r_val3;
    assign o_dots  = r_dots;

endmodule

// ----- rtl/tbc_wmul.sv -----
// Signed wide multiplier, two limbs per operand, three register stages.
module tbc_wmul (
    input  logic                             i_clk,
    input  logic signed [tbc_pkg::DOT_W-1:0]  i_a,
    input  logic signed [tbc_pkg::DOT_W-1:0]  i_b,
    output logic signed [tbc_pkg::PROD_W-1:0] o_p
);
    import tbc_pkg::*;

    localparam int MP_W = PROD_W - 1;

    logic [DMAG_W-1:0]   a_mag, b_mag;
    logic [2*LIMB_W-1:0] r_ll, r_lh, r_hl, r_hh;
    logic                r_neg1, r_neg2;
    logic [MP_W-1:0]     r_mag;
    logic signed [PROD_W-1:0] r_p;

    assign a_mag = i_a[DOT_W-1] ? DMAG_W'(-i_a) : DMAG_W'(i_a);
    assign b_mag = i_b[DOT_W-1] ? DMAG_W'(-i_b) : DMAG_W'(i_b);

    always_ff @(posedge i_clk) begin
        r_ll   <= a_mag[LIMB_W-1:0] * b_mag[LIMB_W-1:0];
        r_lh   <= a_mag[LIMB_W-1:0] * b_mag[DMAG_W-1:LIMB_W];
        r_hl   <= a_mag[DMAG_W-1:LIMB_W] * b_mag[LIMB_W-1:0];
        r_hh   <= a_mag[DMAG_W-1:LIMB_W] * b_mag[DMAG_W-1:LIMB_W];
        r_neg1 <= i_a[DOT_W-1] ^ i_b[DOT_W-1];
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= {r_hh, r_ll} + (MP_W'(r_lh) << LIMB_W) + (MP_W'(r_hl) << LIMB_W);
        r_neg2 <= r_neg1;
    end

    always_ff @(posedge i_clk) begin
        r_p <= r_neg2 ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
    end

    assign o_p = r_p;

endmodule

// ----- rtl/tbc_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, saturated signed result.
module tbc_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [tbc_pkg::MAG_W-1:0]      i_num,
    input  logic [tbc_pkg::MAG_W-1:0]      i_den,
    input  logic                           i_neg,
    input  tbc_pkg::t_tag                  i_tag,
    output tbc_pkg::t_weight               o_quot,
    output logic                           o_sat,
    output tbc_pkg::t_tag                  o_tag
);
    import tbc_pkg::*;

    localparam int DIV_W = MAG_W + QUO_W + 1;

    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] r_rem [QUO_W];
    logic [MAG_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_q   [QUO_W+1];
    logic             r_ovf [QUO_W+1];
    logic             r_neg [QUO_W+1];
    t_tag             r_tag [QUO_W+1];
    t_weight          n_quot, r_quot;
    logic             n_sat, r_sat;
    t_tag             r_otag;
    logic [QUO_W-1:0] q_fin;

    assign dividend = DIV_W'({i_num, {FRAC_BITS{1'b0}}});

    always_ff @(posedge i_clk) begin
        r_rem[0] <= dividend;
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_ovf[0] <= dividend >= (DIV_W'(i_den) << QUO_W);
        r_neg[0] <= i_neg;
        if (!i_rst_n) begin
            r_tag[0] <= '0;
        end else begin
            r_tag[0] <= i_tag;
        end
    end

    for (genvar s = 1; s <= QUO_W; s++) begin : g_bit
        logic [DIV_W-1:0] shifted;
        logic [DIV_W-1:0] trial;
        logic             take;

        assign shifted = DIV_W'(r_den[s-1]) << (QUO_W - s);
        assign take    = r_rem[s-1] >= shifted;
        assign trial   = r_rem[s-1] - shifted;

        always_ff @(posedge i_clk) begin
            r_q[s]   <= {r_q[s-1][QUO_W-2:0], take};
            r_ovf[s] <= r_ovf[s-1];
            r_neg[s] <= r_neg[s-1];
            if (!i_rst_n) begin
                r_tag[s] <= '0;
            end else begin
                r_tag[s] <= r_tag[s-1];
            end
        end

        if (s < QUO_W) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[s] <= take ? trial : r_rem[s-1];
                r_den[s] <= r_den[s-1];
            end
        end
    end

    assign q_fin = r_q[QUO_W];

    always_comb begin
        n_sat  = 1'b0;
        n_quot = $signed(q_fin);
        if (!r_neg[QUO_W]) begin
            if (r_ovf[QUO_W] || q_fin[QUO_W-1]) begin
                n_sat  = 1'b1;
                n_quot = {1'b0, {(WGT_W-1){1'b1}}};
            end
        end else begin
            if (r_ovf[QUO_W] || (q_fin[QUO_W-1] && (|q_fin[QUO_W-2:0]))) begin
                n_sat  = 1'b1;
                n_quot = {1'b1, {(WGT_W-1){1'b0}}};
            end else begin
                n_quot = -$signed(q_fin);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_sat  <= n_sat;
        if (!i_rst_n) begin
            r_otag <= '0;
        end else begin
            r_otag <= r_tag[QUO_W];
        end
    end

    assign o_quot = r_quot;
    assign o_sat  = r_sat;
    assign o_tag  = r_otag;

endmodule

// ----- rtl/triangle_barycentric_coords_unit.sv -----
// Triangle barycentric weight unit: top level.
// Fully pipelined: a transaction can be started in every clock cycle and busy is never
// raised. Each result passes through 45 register stages on its way to o_result and o_valid;
// most of them lie in the divider, which resolves one of its 32 quotient bits per stage.
// Results come out in start order and cannot be held off by the receiver.
module triangle_barycentric_coords_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  tbc_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_valid,
    output tbc_pkg::t_out_item o_result
);
    import tbc_pkg::*;

    localparam int DET_CMP_W = MAG_W + EPS_SHIFT;
    localparam int LEN_CMP_W = DMAG_W + EPS_SHIFT;
    localparam logic [DET_CMP_W-1:0] DET_LIM = DET_CMP_W'(DET_EPS) << (4 * FRAC_BITS);
    localparam logic [LEN_CMP_W-1:0] LEN_LIM = LEN_CMP_W'(LEN_EPS) << (2 * FRAC_BITS);
    localparam logic signed [WGT_W+1:0] ONE  = (WGT_W+2)'(1) << FRAC_BITS;
    localparam t_weight                 HALF = WGT_W'(1) << (FRAC_BITS - 1);

    logic                      dot_valid;
    t_dots                     dots;
    logic signed [PROD_W-1:0]  prod [6];
    t_dots                     r_dd [3];
    logic                      r_dv [3];

    // difference stage
    logic                      r4_valid;
    t_dots                     r4_dots;
    logic signed [DIFF_W-1:0]  r4_det, r4_nb, r4_nc;

    // magnitude stage
    logic                      r5_valid;
    logic [MAG_W-1:0]          r5_det_mag, r5_nb_mag, r5_nc_mag;
    logic                      r5_nb_neg, r5_nc_neg;
    logic                      r5_to_b, r5_b_small, r5_c_small;
    logic [DMAG_W-1:0]         r5_lb, r5_lc, r5_sb_mag, r5_sc_mag;
    logic                      r5_sb_neg, r5_sc_neg;

    // divider operand stage
    logic                      degen;
    logic [MAG_W-1:0]          n6_n0, n6_d0, n6_n1, n6_d1;
    logic                      n6_neg0, n6_neg1;
    t_tag                      n6_tag;
    logic [MAG_W-1:0]          r6_n0, r6_d0, r6_n1, r6_d1;
    logic                      r6_neg0, r6_neg1;
    t_tag                      r6_tag;

    t_weight                   q0, q1;
    logic                      s0, s1;
    t_tag                      dtag;

    t_weight                   n7_wb, n7_wc, r7_wb, r7_wc;
    logic                      n7_sat, r7_sat;
    t_tag                      r7_tag;

    logic signed [WGT_W+1:0]   wa_full;
    t_out_item                 n_out, r_out;
    logic                      r_out_valid;

    assign busy = 1'b0;

    tbc_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_item  (i_item),
        .o_valid (dot_valid),
        .o_dots  (dots)
    );

    tbc_wmul u_mul_det0 (.i_clk(i_clk), .i_a(dots.d00), .i_b(dots.d11), .o_p(prod[0]));
    tbc_wmul u_mul_det1 (.i_clk(i_clk), .i_a(dots.d01), .i_b(dots.d01), .o_p(prod[1]));
    tbc_wmul u_mul_nb0  (.i_clk(i_clk), .i_a(dots.d11), .i_b(dots.d20), .o_p(prod[2]));
    tbc_wmul u_mul_nb1  (.i_clk(i_clk), .i_a(dots.d01), .i_b(dots.d21), .o_p(prod[3]));
    tbc_wmul u_mul_nc0  (.i_clk(i_clk), .i_a(dots.d00), .i_b(dots.d21), .o_p(prod[4]));
    tbc_wmul u_mul_nc1  (.i_clk(i_clk), .i_a(dots.d01), .i_b(dots.d20), .o_p(prod[5]));

    // dots and valid ride alongside the multipliers
    always_ff @(posedge i_clk) begin
        r_dd[0] <= dots;
        r_dd[1] <= r_dd[0];
        r_dd[2] <= r_dd[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0]  <= 1'b0;
            r_dv[1]  <= 1'b0;
            r_dv[2]  <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            r_dv[0]  <= dot_valid;
            r_dv[1]  <= r_dv[0];
            r_dv[2]  <= r_dv[1];
            r4_valid <= r_dv[2];
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_dots <= r_dd[2];
        r4_det  <= DIFF_W'(prod[0]) - DIFF_W'(prod[1]);
        r4_nb   <= DIFF_W'(prod[2]) - DIFF_W'(prod[3]);
        r4_nc   <= DIFF_W'(prod[4]) - DIFF_W'(prod[5]);
    end

    always_ff @(posedge i_clk) begin
        r5_det_mag <= r4_det[DIFF_W-1] ? MAG_W'(-r4_det) : MAG_W'(r4_det);
        r5_nb_mag  <= r4_nb[DIFF_W-1] ? MAG_W'(-r4_nb) : MAG_W'(r4_nb);
        r5_nc_mag  <= r4_nc[DIFF_W-1] ? MAG_W'(-r4_nc) : MAG_W'(r4_nc);
        r5_nb_neg  <= r4_nb[DIFF_W-1];
        r5_nc_neg  <= r4_nc[DIFF_W-1];
        r5_to_b    <= r4_dots.d00 > r4_dots.d11;
        r5_lb      <= DMAG_W'(r4_dots.d00);
        r5_lc      <= DMAG_W'(r4_dots.d11);
        r5_b_small <= {DMAG_W'(r4_dots.d00), {EPS_SHIFT{1'b0}}} < LEN_LIM;
        r5_c_small <= {DMAG_W'(r4_dots.d11), {EPS_SHIFT{1'b0}}} < LEN_LIM;
        r5_sb_mag  <= r4_dots.d20[DOT_W-1] ? DMAG_W'(-r4_dots.d20) : DMAG_W'(r4_dots.d20);
        r5_sc_mag  <= r4_dots.d21[DOT_W-1] ? DMAG_W'(-r4_dots.d21) : DMAG_W'(r4_dots.d21);
        r5_sb_neg  <= r4_dots.d20[DOT_W-1];
        r5_sc_neg  <= r4_dots.d21[DOT_W-1];
    end

    assign degen = {r5_det_mag, {EPS_SHIFT{1'b0}}} < DET_LIM;

    always_comb begin
        n6_n0        = r5_nb_mag;
        n6_d0        = r5_det_mag;
        n6_neg0      = r5_nb_neg;
        n6_n1        = r5_nc_mag;
        n6_d1        = r5_det_mag;
        n6_neg1      = r5_nc_neg;
        n6_tag.valid = r5_valid;
        n6_tag.to_b  = r5_to_b;
        n6_tag.code  = CASE_TRI;
        if (degen) begin
            if (r5_to_b) begin
                n6_n0       = MAG_W'(r5_sb_mag);
                n6_d0       = MAG_W'(r5_lb);
                n6_neg0     = r5_sb_neg;
                n6_tag.code = r5_b_small ? CASE_ZERO : CASE_AB;
            end else begin
                n6_n0       = MAG_W'(r5_sc_mag);
                n6_d0       = MAG_W'(r5_lc);
                n6_neg0     = r5_sc_neg;
                n6_tag.code = r5_c_small ? CASE_ZERO : CASE_AC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r6_n0   <= n6_n0;
        r6_d0   <= n6_d0;
        r6_neg0 <= n6_neg0;
        r6_n1   <= n6_n1;
        r6_d1   <= n6_d1;
        r6_neg1 <= n6_neg1;
        if (!i_rst_n) begin
            r6_tag <= '0;
        end else begin
            r6_tag <= n6_tag;
        end
    end

    tbc_div #(.FRAC_BITS(FRAC_BITS)) u_div0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (r6_n0),
        .i_den   (r6_d0),
        .i_neg   (r6_neg0),
        .i_tag   (r6_tag),
        .o_quot  (q0),
        .o_sat   (s0),
        .o_tag   (dtag)
    );

    tbc_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (r6_n1),
        .i_den   (r6_d1),
        .i_neg   (r6_neg1),
        .i_tag   (r6_tag),
        .o_quot  (q1),
        .o_sat   (s1),
        .o_tag   ()
    );

    always_comb begin
        unique case (dtag.code)
            CASE_TRI: begin
                n7_wb  = q0;
                n7_wc  = q1;
                n7_sat = s0 | s1;
            end
            CASE_AB: begin
                n7_wb  = q0;
                n7_wc  = '0;
                n7_sat = s0;
            end
            CASE_AC: begin
                n7_wb  = '0;
                n7_wc  = q0;
                n7_sat = s0;
            end
            CASE_ZERO: begin
                n7_wb  = dtag.to_b ? HALF : '0;
                n7_wc  = dtag.to_b ? '0 : HALF;
                n7_sat = 1'b0;
            end
            default: begin
                n7_wb  = '0;
                n7_wc  = '0;
                n7_sat = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r7_wb  <= n7_wb;
        r7_wc  <= n7_wc;
        r7_sat <= n7_sat;
        if (!i_rst_n) begin
            r7_tag <= '0;
        end else begin
            r7_tag <= dtag;
        end
    end

    assign wa_full = ONE - (WGT_W+2)'(r7_wb) - (WGT_W+2)'(r7_wc);

    always_comb begin
        n_out.weight_b  = r7_wb;
        n_out.weight_c  = r7_wc;
        n_out.case_code = r7_tag.code;
        n_out.weight_a  = WGT_W'(wa_full);
        n_out.saturated = r7_sat;
        if (wa_full > $signed((WGT_W+2)'({1'b0, {(WGT_W-1){1'b1}}}))) begin
            n_out.weight_a  = {1'b0, {(WGT_W-1){1'b1}}};
            n_out.saturated = 1'b1;
        end else if (wa_full < -$signed((WGT_W+2)'({1'b1, {(WGT_W-1){1'b0}}}))) begin
            n_out.weight_a  = {1'b1, {(WGT_W-1){1'b0}}};
            n_out.saturated = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r7_tag.valid;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
